// ----- sv/rect_pkg.sv -----
package rect_pkg;

  // Field widths
  localparam int unsigned ColW   = 10;
  localparam int unsigned LineW  = 9;
  localparam int unsigned EdgeW  = 8;
  localparam int unsigned SumW   = 18;
  localparam int unsigned CntW   = 9;
  localparam int unsigned RefW   = 12;
  localparam int unsigned DistW  = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Accumulator limits
  localparam logic [CntW-1:0] CntMax = 9'd511;
  localparam logic [SumW:0]   SumMax = 19'd262143;

  // Tracking start bound, squared
  localparam logic [DistW-1:0] StartDistSq = 24'd1000000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW_CUTOFF = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRACK_EN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_X     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_Y     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_Y    = 3'd5;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_LEFT_CENT  = 2'd0,
    KIND_RIGHT_CENT = 2'd1,
    KIND_LEFT_TRK   = 2'd2,
    KIND_RIGHT_TRK  = 2'd3
  } kind_e;

  // Row job handed from the front to the back
  typedef struct packed {
    logic [1:0][SumW-1:0] sum;
    logic [1:0][CntW-1:0] cnt;
    logic [LineW-1:0]     line;
    logic                 used;
    logic                 frame_end;
  } job_t;

  // Tracking configuration seen by the back
  typedef struct packed {
    logic                 track_en;
    logic [1:0][RefW-1:0] ref_x;
    logic [1:0][RefW-1:0] ref_y;
  } trk_cfg_t;

endpackage

// ----- sv/rect_if.sv -----
// Pixel word channel
interface rect_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rect_pkg::ColW-1:0]   column;
  logic [rect_pkg::LineW-1:0]  line;
  logic [rect_pkg::EdgeW-1:0]  edge_value;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, column, line, edge_value, row_end, frame_end, input ready);
  modport sink   (input valid, column, line, edge_value, row_end, frame_end, output ready);
endinterface

// Result word channel
interface rect_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [rect_pkg::ColW-1:0]   point_x;
  logic [rect_pkg::LineW-1:0]  point_y;
  logic                        found;
  logic                        last_of_run;

  modport source (output valid, kind, point_x, point_y, found, last_of_run, input ready);
  modport sink   (input valid, kind, point_x, point_y, found, last_of_run, output ready);
endinterface

// ----- sv/rect_front.sv -----
module rect_front #(
  parameter int unsigned IMAGE_WIDTH = 640
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [rect_pkg::ColW-1:0]  column_i,
  input  logic [rect_pkg::LineW-1:0] line_i,
  input  logic [rect_pkg::EdgeW-1:0] edge_value_i,
  input  logic                       row_end_i,
  input  logic                       frame_end_i,
  input  logic [rect_pkg::LineW-1:0] row_cutoff_i,
  output logic                       push_o,
  output rect_pkg::job_t             job_o
);

  localparam int unsigned CmpW = 13;
  localparam logic [CmpW-1:0] WidthC = CmpW'(IMAGE_WIDTH);
  localparam logic [CmpW-1:0] HalfC  = CmpW'(IMAGE_WIDTH / 2);

  logic [1:0][rect_pkg::SumW-1:0] sum_q, sum_d;
  logic [1:0][rect_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0]                col_w;
  logic                           used;
  logic                           half;
  logic [rect_pkg::SumW:0]        sum_try;
  logic                           take;
  logic                           close;

  assign col_w = {{(CmpW - rect_pkg::ColW){1'b0}}, column_i};
  assign used  = line_i >= row_cutoff_i;
  assign half  = !(col_w < HalfC);
  assign sum_try = {1'b0, sum_q[half]} + {{(rect_pkg::SumW + 1 - rect_pkg::ColW){1'b0}}, column_i};
  assign take  = used && (edge_value_i != '0) && (col_w < WidthC) &&
                 (cnt_q[half] < rect_pkg::CntMax) && (sum_try <= rect_pkg::SumMax);
  assign close = row_end_i || frame_end_i;

  // Accumulate, then hand the closed row to the queue
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept_i && take) begin
      sum_d[half] = sum_try[rect_pkg::SumW-1:0];
      cnt_d[half] = cnt_q[half] + 1'b1;
    end
  end

  assign push_o          = accept_i && close;
  assign job_o.sum       = sum_d;
  assign job_o.cnt       = cnt_d;
  assign job_o.line      = line_i;
  assign job_o.used      = used;
  assign job_o.frame_end = frame_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      if (close) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

// ----- sv/rect_queue.sv -----
module rect_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rect_pkg::job_t push_job_i,
  input  logic           pop_i,
  output rect_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  // Two row jobs waiting for the back
  rect_pkg::job_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;

  assign empty_o = fill_q == 2'd0;
  assign full_o  = fill_q == 2'd2;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("row job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("row job queue underflow");
`endif

endmodule

// ----- sv/rect_back.sv -----
module rect_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rect_pkg::trk_cfg_t         cfg_i,
  input  rect_pkg::job_t             head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [rect_pkg::ColW-1:0]  point_x_o,
  output logic [rect_pkg::LineW-1:0] point_y_o,
  output logic                       found_o,
  output logic                       last_of_run_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PICK = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_NEXT = 3'd5;
  localparam logic [2:0] ST_TRK  = 3'd6;

  localparam int unsigned BitW = $clog2(rect_pkg::SumW + 1);
  localparam int unsigned DifW = 13;

  logic [2:0]                       st_q, st_d;
  rect_pkg::job_t                   job_q;
  logic                             h_q, h_d;
  logic [rect_pkg::CntW-1:0]        rem_q, rem_d;
  logic [rect_pkg::SumW-1:0]        quo_q, quo_d;
  logic [BitW-1:0]                  bit_q, bit_d;
  logic [rect_pkg::DistW-1:0]       dx2_q, dx2_d, dy2_q, dy2_d;
  logic [1:0][rect_pkg::DistW-1:0]  best_d_q, best_d_d;
  logic [1:0][rect_pkg::ColW-1:0]   best_x_q, best_x_d;
  logic [1:0][rect_pkg::LineW-1:0]  best_y_q, best_y_d;
  logic [1:0]                       best_f_q, best_f_d;
  logic                             ov_q, ov_d;
  logic [1:0]                       kind_q, kind_d;
  logic [rect_pkg::ColW-1:0]        px_q, px_d;
  logic [rect_pkg::LineW-1:0]       py_q, py_d;
  logic                             fnd_q, fnd_d;
  logic                             last_q, last_d;

  logic                             slot_free;
  logic [rect_pkg::CntW-1:0]        divisor;
  logic [rect_pkg::CntW:0]          shifted;
  logic [rect_pkg::CntW+1:0]        diff;
  logic signed [DifW-1:0]           dx, dy;
  logic signed [2*DifW-1:0]         dx_sq, dy_sq;
  logic [rect_pkg::DistW:0]         d2;
  logic                             more_after;

  assign slot_free = !ov_q || out_ready_i;
  assign divisor   = job_q.cnt[h_q];

  // Restoring divide step, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[rect_pkg::SumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  // Signed offsets from the reference point
  assign dx = $signed({{(DifW - rect_pkg::ColW){1'b0}}, quo_q[rect_pkg::ColW-1:0]})
            - $signed({cfg_i.ref_x[h_q][rect_pkg::RefW-1], cfg_i.ref_x[h_q]});
  assign dy = $signed({{(DifW - rect_pkg::LineW){1'b0}}, job_q.line})
            - $signed({cfg_i.ref_y[h_q][rect_pkg::RefW-1], cfg_i.ref_y[h_q]});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign d2    = {1'b0, dx2_q} + {1'b0, dy2_q};

  // Another word follows this centroid for the same pixel
  assign more_after = (!h_q && job_q.used && (job_q.cnt[1] != '0)) ||
                      (job_q.frame_end && cfg_i.track_en);

  always_comb begin
    st_d     = st_q;
    h_d      = h_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    bit_d    = bit_q;
    dx2_d    = dx2_q;
    dy2_d    = dy2_q;
    best_d_d = best_d_q;
    best_x_d = best_x_q;
    best_y_d = best_y_q;
    best_f_d = best_f_q;
    ov_d     = ov_q && !out_ready_i;
    kind_d   = kind_q;
    px_d     = px_q;
    py_d     = py_q;
    fnd_d    = fnd_q;
    last_d   = last_q;
    pop_o    = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          h_d   = 1'b0;
          st_d  = ST_PICK;
        end
      end
      ST_PICK: begin
        if (job_q.used && (job_q.cnt[h_q] != '0)) begin
          rem_d = '0;
          quo_d = job_q.sum[h_q];
          bit_d = BitW'(rect_pkg::SumW);
          st_d  = ST_DIV;
        end else begin
          st_d  = ST_NEXT;
        end
      end
      ST_DIV: begin
        if (!diff[rect_pkg::CntW+1]) rem_d = diff[rect_pkg::CntW-1:0];
        else                          rem_d = shifted[rect_pkg::CntW-1:0];
        quo_d = {quo_q[rect_pkg::SumW-2:0], !diff[rect_pkg::CntW+1]};
        bit_d = bit_q - 1'b1;
        if (bit_q == BitW'(1)) st_d = ST_MUL;
      end
      ST_MUL: begin
        dx2_d = dx_sq[rect_pkg::DistW-1:0];
        dy2_d = dy_sq[rect_pkg::DistW-1:0];
        st_d  = ST_ADD;
      end
      ST_ADD: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          kind_d = h_q ? rect_pkg::KIND_RIGHT_CENT : rect_pkg::KIND_LEFT_CENT;
          px_d   = quo_q[rect_pkg::ColW-1:0];
          py_d   = job_q.line;
          fnd_d  = 1'b0;
          last_d = !more_after;
          if (cfg_i.track_en && (d2 < {1'b0, best_d_q[h_q]})) begin
            best_d_d[h_q] = d2[rect_pkg::DistW-1:0];
            best_x_d[h_q] = quo_q[rect_pkg::ColW-1:0];
            best_y_d[h_q] = job_q.line;
            best_f_d[h_q] = 1'b1;
          end
          st_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!h_q) begin
          h_d  = 1'b1;
          st_d = ST_PICK;
        end else if (job_q.frame_end && cfg_i.track_en) begin
          h_d  = 1'b0;
          st_d = ST_TRK;
        end else begin
          if (job_q.frame_end) begin
            best_d_d = {2{rect_pkg::StartDistSq}};
            best_x_d = '0;
            best_y_d = '0;
            best_f_d = '0;
          end
          st_d = ST_IDLE;
        end
      end
      ST_TRK: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          kind_d = h_q ? rect_pkg::KIND_RIGHT_TRK : rect_pkg::KIND_LEFT_TRK;
          px_d   = best_x_q[h_q];
          py_d   = best_y_q[h_q];
          fnd_d  = best_f_q[h_q];
          last_d = h_q;
          if (h_q) begin
            best_d_d = {2{rect_pkg::StartDistSq}};
            best_x_d = '0;
            best_y_d = '0;
            best_f_d = '0;
            st_d     = ST_IDLE;
          end else begin
            h_d = 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Job and datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dx2_q  <= dx2_d;
    dy2_q  <= dy2_d;
    kind_q <= kind_d;
    px_q   <= px_d;
    py_q   <= py_d;
    fnd_q  <= fnd_d;
    last_q <= last_d;
  end

  // Control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      h_q      <= 1'b0;
      bit_q    <= '0;
      ov_q     <= 1'b0;
      best_d_q <= {2{rect_pkg::StartDistSq}};
      best_x_q <= '0;
      best_y_q <= '0;
      best_f_q <= '0;
    end else begin
      st_q     <= st_d;
      h_q      <= h_d;
      bit_q    <= bit_d;
      ov_q     <= ov_d;
      best_d_q <= best_d_d;
      best_x_q <= best_x_d;
      best_y_q <= best_y_d;
      best_f_q <= best_f_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign found_o       = fnd_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_cent_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (kind_q == rect_pkg::KIND_LEFT_CENT || kind_q == rect_pkg::KIND_RIGHT_CENT))
      |-> !fnd_q) else $error("centroid word flagged as found");
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_d_q[0] <= rect_pkg::StartDistSq) && (best_d_q[1] <= rect_pkg::StartDistSq))
    else $error("tracked distance above start bound");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (bit_q != '0)) else $error("divider ran past its last bit");
`endif

endmodule

// ----- sv/row_edge_centroid_tracker_top.sv -----
// Channel  Dir  Word
// pix_i    in   column, line, edge_value, row_end, frame_end
// res_o    out  kind, point_x, point_y, found, last_of_run
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One pixel per clock is taken while the row queue (two jobs) has room.
// Each row end costs the back a load of the job, then for each half that holds
// edge pixels the steps pick, restoring divide, one multiply stage, add/compare
// and step, or pick and step for an empty half, plus one tracked word per half
// at frame end when tracking is on.
// Reset is asynchronous and clears all control and tracking state at once.
// A stalled result holds in the output register; the queue absorbs row ends.
module row_edge_centroid_tracker_top #(
  parameter int unsigned IMAGE_WIDTH = 640
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rect_pix_if.sink                       pix_i,
  rect_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [rect_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rect_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [rect_pkg::LineW-1:0] row_cutoff_q;
  rect_pkg::trk_cfg_t         trk_q;
  logic                       accept;
  logic                       push, pop, empty, full;
  rect_pkg::job_t             push_job, head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cutoff_q   <= '0;
      trk_q.track_en <= 1'b1;
      trk_q.ref_x    <= '0;
      trk_q.ref_y    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rect_pkg::CFG_ROW_CUTOFF: row_cutoff_q   <= cfg_data_i[rect_pkg::LineW-1:0];
        rect_pkg::CFG_TRACK_EN:   trk_q.track_en <= cfg_data_i[0];
        rect_pkg::CFG_LEFT_X:     trk_q.ref_x[0] <= cfg_data_i;
        rect_pkg::CFG_LEFT_Y:     trk_q.ref_y[0] <= cfg_data_i;
        rect_pkg::CFG_RIGHT_X:    trk_q.ref_x[1] <= cfg_data_i;
        rect_pkg::CFG_RIGHT_Y:    trk_q.ref_y[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix_i.ready = !full;
  assign accept      = pix_i.valid && !full;

  rect_front #(
    .IMAGE_WIDTH(IMAGE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .column_i     (pix_i.column),
    .line_i       (pix_i.line),
    .edge_value_i (pix_i.edge_value),
    .row_end_i    (pix_i.row_end),
    .frame_end_i  (pix_i.frame_end),
    .row_cutoff_i (row_cutoff_q),
    .push_o       (push),
    .job_o        (push_job)
  );

  rect_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  rect_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (trk_q),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .kind_o        (res_o.kind),
    .point_x_o     (res_o.point_x),
    .point_y_o     (res_o.point_y),
    .found_o       (res_o.found),
    .last_of_run_o (res_o.last_of_run)
  );

endmodule

// ----- tb/row_edge_centroid_tracker_checker.sv -----
`timescale 1ns / 1ps

// Watches the pixel, result and config ports, predicts every result word
// and compares it, in order, with what the block delivers.
module row_edge_centroid_tracker_checker #(
  parameter int unsigned IMAGE_WIDTH = 640
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rect_pix_if                            pix_i,
  rect_res_if                            res_i,
  input  logic                           cfg_we_i,
  input  logic [rect_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rect_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                    err_count_o,
  output int unsigned                    pending_o
);

  localparam int unsigned MaxReports = 50;

  typedef struct packed {
    rect_pkg::kind_e            kind;
    logic [rect_pkg::ColW-1:0]  x;
    logic [rect_pkg::LineW-1:0] y;
    logic                       found;
    logic                       last;
  } point_word_t;

  // Result words still owed by the block, oldest first
  point_word_t expected_points[$];

  // Register shadow
  logic [rect_pkg::LineW-1:0]       cutoff;
  logic                             track_en;
  logic signed [rect_pkg::RefW-1:0] ref_x [2];
  logic signed [rect_pkg::RefW-1:0] ref_y [2];

  // Row accumulators and per-frame nearest point, index 0 left, 1 right
  logic [rect_pkg::SumW-1:0]   row_sum   [2];
  logic [rect_pkg::CntW-1:0]   row_cnt   [2];
  logic [rect_pkg::DistW-1:0]  best_dsq  [2];
  logic [rect_pkg::ColW-1:0]   best_x    [2];
  logic [rect_pkg::LineW-1:0]  best_y    [2];
  logic                        best_found[2];

  function automatic void clear_nearest();
    for (int h = 0; h < 2; h++) begin
      best_dsq[h]   = rect_pkg::StartDistSq;
      best_x[h]     = '0;
      best_y[h]     = '0;
      best_found[h] = 1'b0;
    end
  endfunction

  // Accumulate one pixel word and queue the result words it closes out
  task automatic track_pixel(input logic [rect_pkg::ColW-1:0] column,
                             input logic [rect_pkg::LineW-1:0] line,
                             input logic [rect_pkg::EdgeW-1:0] edge_v, input logic row_end,
                             input logic frame_end);
    logic        used;
    int          h;
    int          cx;
    int          dx;
    int          dy;
    int          d2;
    int          first_new;
    point_word_t w;
    first_new = expected_points.size();
    used = (line >= cutoff);

    if (used && edge_v != '0 && column < IMAGE_WIDTH) begin
      h = (column < IMAGE_WIDTH / 2) ? 0 : 1;
      // saturated half drops the pixel
      if (row_cnt[h] < rect_pkg::CntMax &&
          int'(row_sum[h]) + int'(column) <= int'(rect_pkg::SumMax)) begin
        row_sum[h] = row_sum[h] + column;
        row_cnt[h] = row_cnt[h] + 1'b1;
      end
    end

    // row close: centroid per half, then nearest-point update
    if (row_end || frame_end) begin
      for (h = 0; h < 2; h++) begin
        if (used && row_cnt[h] != '0) begin
          cx = int'(row_sum[h]) / int'(row_cnt[h]);
          w.kind  = (h == 0) ? rect_pkg::KIND_LEFT_CENT : rect_pkg::KIND_RIGHT_CENT;
          w.x     = cx[rect_pkg::ColW-1:0];
          w.y     = line;
          w.found = 1'b0;
          w.last  = 1'b0;
          expected_points.insert(expected_points.size(), w);
          if (track_en) begin
            dx = cx - int'(ref_x[h]);
            dy = int'(line) - int'(ref_y[h]);
            d2 = dx * dx + dy * dy;
            if (d2 < int'(best_dsq[h])) begin
              best_dsq[h]   = d2[rect_pkg::DistW-1:0];
              best_x[h]     = cx[rect_pkg::ColW-1:0];
              best_y[h]     = line;
              best_found[h] = 1'b1;
            end
          end
        end
        row_sum[h] = '0;
        row_cnt[h] = '0;
      end
    end

    // frame close: report nearest points, then start over
    if (frame_end) begin
      if (track_en) begin
        for (h = 0; h < 2; h++) begin
          w.kind  = (h == 0) ? rect_pkg::KIND_LEFT_TRK : rect_pkg::KIND_RIGHT_TRK;
          w.x     = best_x[h];
          w.y     = best_y[h];
          w.found = best_found[h];
          w.last  = 1'b0;
          expected_points.insert(expected_points.size(), w);
        end
      end
      clear_nearest();
    end

    if (expected_points.size() > first_new)
      expected_points[expected_points.size() - 1].last = 1'b1;
  endtask

  function automatic void flag_field(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
    if (err_count_o < MaxReports)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    err_count_o++;
  endfunction

  // Compare one delivered result word against the oldest prediction
  task automatic check_point();
    point_word_t w;
    if (expected_points.size() == 0) begin
      if (err_count_o < MaxReports)
        $display("%0t: unexpected result word, expected none, actual kind %0d x %0d y %0d",
                 $time, res_i.kind, res_i.point_x, res_i.point_y);
      err_count_o++;
    end else begin
      w = expected_points.pop_front();
      if (res_i.kind !== w.kind)
        flag_field("kind", 32'(w.kind), 32'(res_i.kind));
      if (res_i.point_x !== w.x)
        flag_field("point_x", 32'(w.x), 32'(res_i.point_x));
      if (res_i.point_y !== w.y)
        flag_field("point_y", 32'(w.y), 32'(res_i.point_y));
      if (res_i.found !== w.found)
        flag_field("found", 32'(w.found), 32'(res_i.found));
      if (res_i.last_of_run !== w.last)
        flag_field("last_of_run", 32'(w.last), 32'(res_i.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff   = '0;
      track_en = 1'b1;
      for (int h = 0; h < 2; h++) begin
        ref_x[h]   = '0;
        ref_y[h]   = '0;
        row_sum[h] = '0;
        row_cnt[h] = '0;
      end
      clear_nearest();
      expected_points.delete();
      err_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rect_pkg::CFG_ROW_CUTOFF: cutoff   = cfg_data_i[rect_pkg::LineW-1:0];
          rect_pkg::CFG_TRACK_EN:   track_en = cfg_data_i[0];
          rect_pkg::CFG_LEFT_X:     ref_x[0] = cfg_data_i;
          rect_pkg::CFG_LEFT_Y:     ref_y[0] = cfg_data_i;
          rect_pkg::CFG_RIGHT_X:    ref_x[1] = cfg_data_i;
          rect_pkg::CFG_RIGHT_Y:    ref_y[1] = cfg_data_i;
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) check_point();
      if (pix_i.valid && pix_i.ready)
        track_pixel(pix_i.column, pix_i.line, pix_i.edge_value, pix_i.row_end,
                    pix_i.frame_end);
    end
    pending_o = expected_points.size();
  end

endmodule

// ----- tb/row_edge_centroid_tracker_top_tb.sv -----
`timescale 1ns / 1ps

module row_edge_centroid_tracker_top_tb;

  localparam int unsigned IMAGE_WIDTH  = 640;
  localparam int          SETTLE       = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          TOTAL_ITEMS  = 350;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [rect_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rect_pkg::CfgDataW-1:0] cfg_data_i;

  int unsigned err_count;
  int unsigned pending;
  int          quiet_cycles = 0;
  int          sent_words = 0;

  logic [rect_pkg::LineW-1:0] cur_cutoff = '0;
  bit               steady_send = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_active = 1'b0;

  rect_pix_if pix_ch ();
  rect_res_if res_ch ();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  row_edge_centroid_tracker_top #(
    .IMAGE_WIDTH(IMAGE_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  row_edge_centroid_tracker_checker #(
    .IMAGE_WIDTH(IMAGE_WIDTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_ch),
    .res_i       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Reference point: mostly inside the image, sometimes at the register extremes
  function automatic logic signed [rect_pkg::RefW-1:0] pick_ref(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return rect_pkg::RefW'($urandom_range(0, span));
    if (r < 85) return ($urandom_range(0, 1) != 0) ? 12'sd2047 : -12'sd2048;
    return rect_pkg::RefW'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  // Offer one pixel word and hold it until taken
  task automatic send_pixel(input logic [rect_pkg::ColW-1:0] column,
                            input logic [rect_pkg::LineW-1:0] line,
                            input logic [rect_pkg::EdgeW-1:0] edge_v, input logic row_end,
                            input logic frame_end);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.column     <= column;
    pix_ch.line       <= line;
    pix_ch.edge_value <= edge_v;
    pix_ch.row_end    <= row_end;
    pix_ch.frame_end  <= frame_end;
    do @(posedge clk_i); while (!pix_ch.ready);
    sent_words++;
  endtask

  // Stop offering, drain every owed word, then let the pipeline empty
  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [rect_pkg::LineW-1:0] cut, input logic en,
                              input logic signed [rect_pkg::RefW-1:0] lx,
                              input logic signed [rect_pkg::RefW-1:0] ly,
                              input logic signed [rect_pkg::RefW-1:0] rx,
                              input logic signed [rect_pkg::RefW-1:0] ry);
    logic [rect_pkg::CfgIdxW-1:0]  regs [6];
    logic [rect_pkg::CfgDataW-1:0] vals [6];
    regs = '{rect_pkg::CFG_ROW_CUTOFF, rect_pkg::CFG_TRACK_EN, rect_pkg::CFG_LEFT_X,
             rect_pkg::CFG_LEFT_Y, rect_pkg::CFG_RIGHT_X, rect_pkg::CFG_RIGHT_Y};
    vals = '{rect_pkg::CfgDataW'(cut), rect_pkg::CfgDataW'(en), lx, ly, rx, ry};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cutoff = cut;
  endtask

  // One frame of short rows with random content, a little noise mixed in
  task automatic send_frame();
    int                         nrows;
    int                         npix;
    int                         r;
    logic [rect_pkg::LineW-1:0] ln;
    logic [rect_pkg::ColW-1:0]  col;
    logic [rect_pkg::EdgeW-1:0] ev;
    logic                       re;
    logic                       fe;
    nrows = $urandom_range(1, 5);
    if ($urandom_range(0, 99) < 80 && int'(cur_cutoff) <= 479 - nrows)
      ln = rect_pkg::LineW'($urandom_range(int'(cur_cutoff), 479 - nrows));
    else
      ln = rect_pkg::LineW'($urandom_range(0, 479 - nrows));
    for (int row = 0; row < nrows; row++) begin
      npix = $urandom_range(1, 12);
      for (int p = 0; p < npix; p++) begin
        r = $urandom_range(0, 99);
        if (r < 88)      col = rect_pkg::ColW'($urandom_range(0, IMAGE_WIDTH - 1));
        else if (r < 94) col = rect_pkg::ColW'($urandom_range(IMAGE_WIDTH, 1023));
        else             col = (r < 96) ? 10'd319 : ((r < 98) ? 10'd320 : 10'd0);
        r = $urandom_range(0, 99);
        ev = (r < 45) ? 8'd0 : ((r < 55) ? 8'd255 : 8'($urandom_range(1, 254)));
        re = (p == npix - 1);
        fe = re && (row == nrows - 1);
        if (fe) re = ($urandom_range(0, 9) < 7);
        // noise word: any field values at all
        if (!re && !fe && $urandom_range(0, 99) < 8)
          send_pixel(rect_pkg::ColW'($urandom_range(0, 1023)),
                     rect_pkg::LineW'($urandom_range(0, 479)),
                     rect_pkg::EdgeW'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 19) == 0));
        else
          send_pixel(col, ln, ev, re, fe);
      end
      ln++;
    end
  endtask

  // Result side: random ready, plus one long hold-off on request
  initial begin : result_sink
    int run;
    int stall;
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end
      res_ch.ready <= 1'b1;
      run = $urandom_range(1, 30);
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int nframes;
    int phase;
    logic [rect_pkg::LineW-1:0] cut;
    phase = 0;

    pix_ch.valid      <= 1'b0;
    pix_ch.column     <= '0;
    pix_ch.line       <= '0;
    pix_ch.edge_value <= '0;
    pix_ch.row_end    <= 1'b0;
    pix_ch.frame_end  <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= rect_pkg::CFG_ROW_CUTOFF;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: half edges, out-of-image columns, empty row end,
    // a tie on the left (first row keeps it), frame end without row end
    send_pixel(10'd0,    9'd0,   8'd255, 1'b0, 1'b0);
    send_pixel(10'd319,  9'd0,   8'd1,   1'b0, 1'b0);
    send_pixel(10'd320,  9'd0,   8'd128, 1'b0, 1'b0);
    send_pixel(10'd639,  9'd0,   8'd255, 1'b0, 1'b0);
    send_pixel(10'd640,  9'd0,   8'd255, 1'b0, 1'b0);
    send_pixel(10'd1023, 9'd0,   8'd255, 1'b1, 1'b0);
    send_pixel(10'd5,    9'd1,   8'd0,   1'b1, 1'b0);
    send_pixel(10'd4,    9'd3,   8'd2,   1'b1, 1'b0);
    send_pixel(10'd0,    9'd5,   8'd3,   1'b1, 1'b0);
    send_pixel(10'd100,  9'd479, 8'd7,   1'b0, 1'b0);
    send_pixel(10'd500,  9'd479, 8'd0,   1'b0, 1'b1);
    // frame with nothing found
    send_pixel(10'd0,    9'd2,   8'd0,   1'b0, 1'b1);
    settle();

    // Tracking off: ignored row end, lone centroid, silent frame end
    write_config(9'd200, 1'b0, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
    send_pixel(10'd10,   9'd100, 8'd9,   1'b1, 1'b0);
    send_pixel(10'd600,  9'd300, 8'd1,   1'b1, 1'b0);
    send_pixel(10'd0,    9'd300, 8'd0,   1'b0, 1'b1);
    settle();

    // Top cutoff, references far away so nothing is found
    write_config(9'd479, 1'b1, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
    send_pixel(10'd300,  9'd478, 8'd5,   1'b1, 1'b0);
    send_pixel(10'd30,   9'd479, 8'd255, 1'b0, 1'b0);
    send_pixel(10'd631,  9'd479, 8'd64,  1'b0, 1'b1);
    settle();

    // Random phases, each with fresh settings
    while (sent_words < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       cut = 9'd0;
        1:       cut = 9'd479;
        2, 3:    cut = rect_pkg::LineW'($urandom_range(0, 479));
        default: cut = rect_pkg::LineW'($urandom_range(0, 60));
      endcase
      // keep every row in use so the hold-off backs the block up
      if (phase == 1) cut = '0;
      write_config(cut, ($urandom_range(0, 3) != 0), pick_ref(639), pick_ref(479),
                   pick_ref(639), pick_ref(479));
      steady_send = ($urandom_range(0, 4) == 0);
      nframes = $urandom_range(1, 3);
      // the receiver holds off while frames keep coming
      if (phase == 1 || $urandom_range(0, 7) == 0) begin
        steady_send = 1'b1;
        nframes = 4;
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
      end
      for (int f = 0; f < nframes; f++) begin
        send_frame();
      end
      steady_send = 1'b0;
      settle();
      phase++;
    end

    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
